// ===== design/fswp_pkg.sv =====
// Shared constants, word types and the arctangent table for the wrapped phase core.
package fswp_pkg;

  localparam int INTENSITY_BITS = 8;
  localparam int PHASE_BITS     = 16;
  localparam int CORDIC_STEPS   = 28;
  localparam int PRE_SCALE      = 20;
  localparam int ACC_BITS       = 32;
  // magnitude stays below 2^(INTENSITY_BITS + PRE_SCALE + 2) including CORDIC gain
  localparam int DATA_BITS      = INTENSITY_BITS + PRE_SCALE + 3;
  localparam int STEP_BITS      = $clog2(CORDIC_STEPS);

  localparam logic [PHASE_BITS-1:0] PHASE_ZERO          = '0;
  localparam logic [PHASE_BITS-1:0] PHASE_QUARTER       = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [PHASE_BITS-1:0] PHASE_HALF          = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [PHASE_BITS-1:0] PHASE_THREE_QUARTER = PHASE_QUARTER | PHASE_HALF;
  localparam logic [ACC_BITS-1:0]   ACC_HALF_TURN       = ACC_BITS'(1) << (ACC_BITS - 1);
  localparam logic [ACC_BITS-1:0]   ACC_ROUND           = ACC_BITS'(1) << (ACC_BITS - 1 - PHASE_BITS);

  typedef struct packed {
    logic [INTENSITY_BITS-1:0] intensity_0;
    logic [INTENSITY_BITS-1:0] intensity_1;
    logic [INTENSITY_BITS-1:0] intensity_2;
    logic [INTENSITY_BITS-1:0] intensity_3;
  } in_word_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] wrapped_phase;
    logic                  phase_undefined;
  } out_word_t;

  typedef struct packed {
    logic                        valid;
    logic                        special;
    logic                        undef;
    logic [PHASE_BITS-1:0]       fixed_phase;
    logic signed [DATA_BITS-1:0] x;
    logic signed [DATA_BITS-1:0] y;
    logic [ACC_BITS-1:0]         acc;
  } cordic_word_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [ACC_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] step);
    logic [ACC_BITS-1:0] val;
    case (step)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/four_step_wrapped_phase_core.sv =====
// Top level: four-step wrapped phase pipeline from entry stage through CORDIC cells to output.
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | fswp_pkg::in_word_t (four intensities)
//   out_    | output    | out_valid/out_stall | fswp_pkg::out_word_t (phase, undefined flag)
// One word per cycle while the chain is not held; stages: entry stage, 28 CORDIC cells, rounding register.
// The whole chain advances together; it holds only while out_valid is high and out_stall is high.
// in_stall is high exactly in those cycles.
// Synchronous active-low reset clears the valid bits of every stage.
module four_step_wrapped_phase_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fswp_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fswp_pkg::out_word_t  out_word
);

  fswp_pkg::cordic_word_t stage_w [0:fswp_pkg::CORDIC_STEPS];
  logic                   pipe_en;

  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  fswp_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .word_o   (stage_w[0])
  );

  for (genvar g = 0; g < fswp_pkg::CORDIC_STEPS; g++) begin : g_cell
    fswp_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .step_idx (fswp_pkg::STEP_BITS'(g)),
      .word_i   (stage_w[g]),
      .word_o   (stage_w[g+1])
    );
  end

  fswp_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .word_i    (stage_w[fswp_pkg::CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.phase_undefined |-> out_word.wrapped_phase == '0)
    else $error("undefined phase word carries nonzero phase");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !stage_w[0].valid)
    else $error("pipeline not empty after reset");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(stage_w[fswp_pkg::CORDIC_STEPS].valid)
                 && $stable(stage_w[fswp_pkg::CORDIC_STEPS].acc))
    else $error("last cell moved while chain held");

  a_special_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && stage_w[fswp_pkg::CORDIC_STEPS].valid && stage_w[fswp_pkg::CORDIC_STEPS].special
    |=> out_word.wrapped_phase == $past(stage_w[fswp_pkg::CORDIC_STEPS].fixed_phase))
    else $error("axis phase lost at output");

endmodule

// ===== design/fswp_prep.sv =====
// Entry stage: intensity differences, axis cases and half-turn pre-rotation.
module fswp_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  fswp_pkg::in_word_t      in_word,
  output fswp_pkg::cordic_word_t  word_o
);

  logic signed [fswp_pkg::INTENSITY_BITS:0] dx;
  logic signed [fswp_pkg::INTENSITY_BITS:0] dy;
  logic signed [fswp_pkg::INTENSITY_BITS:0] mx;
  logic signed [fswp_pkg::INTENSITY_BITS:0] my;
  logic                                     x_zero;
  logic                                     y_zero;
  fswp_pkg::cordic_word_t                   word_nxt;
  fswp_pkg::cordic_word_t                   word_r;

  always_comb begin
    dx = $signed({1'b0, in_word.intensity_0}) - $signed({1'b0, in_word.intensity_2});
    dy = $signed({1'b0, in_word.intensity_3}) - $signed({1'b0, in_word.intensity_1});
    x_zero = (dx == '0);
    y_zero = (dy == '0);
    mx = dx[fswp_pkg::INTENSITY_BITS] ? -dx : dx;
    my = dx[fswp_pkg::INTENSITY_BITS] ? -dy : dy;

    word_nxt.valid   = in_valid;
    word_nxt.special = x_zero || y_zero;
    word_nxt.undef   = x_zero && y_zero;
    if (y_zero) begin
      word_nxt.fixed_phase = (x_zero || !dx[fswp_pkg::INTENSITY_BITS]) ?
                             fswp_pkg::PHASE_ZERO : fswp_pkg::PHASE_HALF;
    end else begin
      word_nxt.fixed_phase = dy[fswp_pkg::INTENSITY_BITS] ?
                             fswp_pkg::PHASE_THREE_QUARTER : fswp_pkg::PHASE_QUARTER;
    end
    word_nxt.x   = fswp_pkg::DATA_BITS'(mx) <<< fswp_pkg::PRE_SCALE;
    word_nxt.y   = fswp_pkg::DATA_BITS'(my) <<< fswp_pkg::PRE_SCALE;
    word_nxt.acc = dx[fswp_pkg::INTENSITY_BITS] ? fswp_pkg::ACC_HALF_TURN : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

// ===== design/fswp_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
module fswp_cordic_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic [fswp_pkg::STEP_BITS-1:0]      step_idx,
  input  fswp_pkg::cordic_word_t              word_i,
  output fswp_pkg::cordic_word_t              word_o
);

  logic signed [fswp_pkg::DATA_BITS-1:0] xs;
  logic signed [fswp_pkg::DATA_BITS-1:0] ys;
  logic [fswp_pkg::ACC_BITS-1:0]         ang;
  logic                                  y_pos;
  fswp_pkg::cordic_word_t                word_nxt;
  fswp_pkg::cordic_word_t                word_r;

  always_comb begin
    xs    = word_i.x >>> step_idx;
    ys    = word_i.y >>> step_idx;
    ang   = fswp_pkg::atan_turn(step_idx);
    y_pos = !word_i.y[fswp_pkg::DATA_BITS-1] && (word_i.y != '0);
    word_nxt = word_i;
    if (y_pos) begin
      word_nxt.x   = word_i.x + ys;
      word_nxt.y   = word_i.y - xs;
      word_nxt.acc = word_i.acc + ang;
    end else begin
      word_nxt.x   = word_i.x - ys;
      word_nxt.y   = word_i.y + xs;
      word_nxt.acc = word_i.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

// ===== design/fswp_round.sv =====
// Output stage: rounds the turn accumulator and selects axis results.
module fswp_round (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  fswp_pkg::cordic_word_t  word_i,
  output logic                    out_valid,
  output fswp_pkg::out_word_t     out_word
);

  logic [fswp_pkg::ACC_BITS-1:0] acc_sum;
  fswp_pkg::out_word_t           res_nxt;
  fswp_pkg::out_word_t           res_r;
  logic                          valid_r;

  always_comb begin
    acc_sum = word_i.acc + fswp_pkg::ACC_ROUND;
    res_nxt.phase_undefined = word_i.undef && word_i.special;
    if (word_i.special) begin
      res_nxt.wrapped_phase = word_i.fixed_phase;
    end else begin
      res_nxt.wrapped_phase = acc_sum[fswp_pkg::ACC_BITS-1 -: fswp_pkg::PHASE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= word_i.valid;
      res_r   <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = res_r;

endmodule
